[src/ecp_pkg.sv]
// shared constants, types and helper functions of the escape count color palette
package ecp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int MAX_WIDTH   = 16;
    localparam int MODE_WIDTH  = 4;
    localparam int IDX_WIDTH   = 4;
    localparam int CFG_WIDTH   = 16;
    localparam int RGB_WIDTH   = 24;

    // pipeline depth: input stage, eight divider stages, three product stages, output
    localparam int DIV_STAGES = 8;
    localparam int LAST_STAGE = 12;

    // configuration register indexes
    localparam logic [IDX_WIDTH-1:0] REG_MODE = 4'd0;
    localparam logic [IDX_WIDTH-1:0] REG_MAX  = 4'd1;

    // palette selector codes
    localparam logic [MODE_WIDTH-1:0] MODE_POLY   = 4'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_RED    = 4'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_GREEN  = 4'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_BLUE   = 4'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_SINE_A = 4'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_MOD    = 4'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_SINE_B = 4'd6;
    localparam logic [MODE_WIDTH-1:0] MODE_MUL_A  = 4'd7;
    localparam logic [MODE_WIDTH-1:0] MODE_MUL_B  = 4'd8;

    localparam logic [MAX_WIDTH-1:0] MAX_RESET = 16'd256;

    // sine phase increments and offsets, 2^32 steps per turn, red/green/blue
    localparam logic [31:0] SINE_A_INC [3] = '{32'd10937044, 32'd8886349, 32'd6835653};
    localparam logic [31:0] SINE_A_OFS [3] = '{32'd2734261102, 32'd1367130551, 32'd683565276};
    localparam logic [31:0] SINE_B_INC [3] = '{32'd68356528, 32'd102534791, 32'd136713055};
    localparam logic [31:0] SINE_B_OFS [3] = '{32'd0, 32'd1367130551, 32'd2734261102};

    // quarter sine polynomial coefficients, Q1.15
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    // one restoring division step: quotient bit on top, new remainder below
    function automatic logic [MAX_WIDTH:0] div_step(input logic [MAX_WIDTH-1:0] rem,
                                                    input logic [MAX_WIDTH-1:0] dvs);
        logic [MAX_WIDTH:0] r2;
        logic               qb;
        r2 = {rem, 1'b0};
        qb = (r2 >= {1'b0, dvs});
        if (qb) begin
            r2 = r2 - {1'b0, dvs};
        end
        return {qb, r2[MAX_WIDTH-1:0]};
    endfunction

    // contents of one pipeline stage
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic [MAX_WIDTH-1:0]   maxc;
        logic [MODE_WIDTH-1:0]  mode;
        logic [MAX_WIDTH-1:0]   rem;
        logic [15:0]            quo;
        logic [16:0]            pr;
        logic [16:0]            pg;
        logic [16:0]            pb;
        logic [7:0]             sr;
        logic [7:0]             sg;
        logic [7:0]             sb;
    } t_stage;

endpackage

[src/ecp_if.sv]
// handshake interfaces for count input, color output and configuration writes
interface ecp_cnt_if;
    logic                            valid;
    logic                            ready;
    logic [ecp_pkg::COUNT_WIDTH-1:0] count;
    modport source (output valid, output count, input ready);
    modport sink (input valid, input count, output ready);
endinterface

interface ecp_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [ecp_pkg::RGB_WIDTH-1:0] rgb;
    modport source (output valid, output rgb, input ready);
    modport sink (input valid, input rgb, output ready);
endinterface

interface ecp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ecp_pkg::IDX_WIDTH-1:0] index;
    logic [ecp_pkg::CFG_WIDTH-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/ecp_sine_lane.sv]
// seven stage sine channel: phase, quadrant fold, polynomial and bias
module ecp_sine_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [ecp_pkg::COUNT_WIDTH-1:0] i_cnt,
    input  logic [31:0]                     i_inc,
    input  logic [31:0]                     i_ofs,
    input  logic                            i_hi_bias,
    output logic [7:0]                      o_chan
);

    logic [15:0] r_ph1;
    logic        r_b1, r_b2, r_b3, r_b4, r_b5, r_b6;
    logic [1:0]  r_q2, r_q3, r_q4, r_q5, r_q6;
    logic [15:0] r_z2_15, r_z3_15, r_z4_15, r_z5_15;
    logic [15:0] r_z3sq, r_z4sq;
    logic [14:0] r_t2;
    logic [15:0] r_t4;
    logic [15:0] r_m6;
    logic [7:0]  r_chan;

    logic [ecp_pkg::COUNT_WIDTH+31:0] n_prod;
    logic [31:0] n_phase;
    logic [13:0] n_off;
    logic [14:0] n_z;
    logic [31:0] n_sq;
    logic [27:0] n_t1p;
    logic [11:0] n_t1;
    logic [30:0] n_t3p;
    logic [15:0] n_t3;
    logic [31:0] n_sp;
    logic [16:0] n_s;
    logic [22:0] n_m127;
    logic [7:0]  n_d;
    logic [7:0]  n_bias;
    logic [8:0]  n_sum;
    logic [7:0]  n_chan;

    // per stage arithmetic
    always_comb begin
        n_prod  = ecp_pkg::COUNT_WIDTH'(0) + i_cnt * i_inc;
        n_phase = n_prod[31:0] + i_ofs;
        n_off   = r_ph1[13:0];
        n_z     = r_ph1[14] ? (15'd16384 - {1'b0, n_off}) : {1'b0, n_off};
        n_sq    = r_z2_15 * r_z2_15;
        n_t1p   = 28'(r_z3sq) * 28'(ecp_pkg::SIN_C);
        n_t1    = n_t1p[26:15];
        n_t3p   = 31'(r_z4sq) * 31'(r_t2);
        n_t3    = n_t3p[30:15];
        n_sp    = r_z5_15 * r_t4;
        n_s     = n_sp[31:15];
        n_m127  = 23'(r_m6) * 23'd127;
        n_bias  = r_b6 ? 8'd128 : 8'd127;
        if (!r_q6[1]) begin
            n_d    = 8'(n_m127 >> 15);
            n_sum  = {1'b0, n_bias} + {1'b0, n_d};
            n_chan = n_sum[8] ? 8'd255 : n_sum[7:0];
        end else begin
            n_d    = 8'((n_m127 + 23'd32767) >> 15);
            n_sum  = '0;
            n_chan = (n_d > n_bias) ? 8'd0 : (n_bias - n_d);
        end
    end

    // lane registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph1   <= n_phase[31:16];
            r_b1    <= i_hi_bias;
            r_q2    <= r_ph1[15:14];
            r_z2_15 <= {n_z, 1'b0};
            r_b2    <= r_b1;
            r_q3    <= r_q2;
            r_z3_15 <= r_z2_15;
            r_z3sq  <= n_sq[30:15];
            r_b3    <= r_b2;
            r_q4    <= r_q3;
            r_z4_15 <= r_z3_15;
            r_z4sq  <= r_z3sq;
            r_t2    <= 15'(ecp_pkg::SIN_B) - 15'(n_t1);
            r_b4    <= r_b3;
            r_q5    <= r_q4;
            r_z5_15 <= r_z4_15;
            r_t4    <= ecp_pkg::SIN_A - n_t3;
            r_b5    <= r_b4;
            r_q6    <= r_q5;
            r_m6    <= (n_s > 17'd32768) ? 16'd32768 : n_s[15:0];
            r_b6    <= r_b5;
            r_chan  <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

[src/escape_count_color_palette.sv]
// top level: escape count to rgb palette pipeline
// One pixel per clock: a count beat is accepted whenever the output register is empty or being
// taken, and its color is offered once it reaches the output register (thirteen register
// stages: one input stage, eight divider stages retiring two quotient bits each for
// t = count*65536/max, three product stages, one output register). The pipeline advances as a
// whole, so a stall at the output holds every stage. Configuration writes are always taken and
// should be made while no pixel is in flight.
module escape_count_color_palette (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecp_cfg_if.sink       i_cfg,
    ecp_cnt_if.sink       i_pix,
    ecp_rgb_if.source     o_pix
);

    logic [ecp_pkg::MODE_WIDTH-1:0] r_mode;
    logic [ecp_pkg::MAX_WIDTH-1:0]  r_max;
    logic                           r_vld [ecp_pkg::LAST_STAGE+1];
    ecp_pkg::t_stage                r_st  [ecp_pkg::LAST_STAGE];
    ecp_pkg::t_stage                n_st  [ecp_pkg::LAST_STAGE];
    logic [ecp_pkg::RGB_WIDTH-1:0]  r_rgb;
    logic [ecp_pkg::RGB_WIDTH-1:0]  n_rgb;
    logic                           w_en;
    logic                           w_sine_b;
    logic [7:0]                     w_sc [3];

    // whole pipeline moves when the output slot is free
    assign w_en        = !r_vld[ecp_pkg::LAST_STAGE] || o_pix.ready;
    assign i_pix.ready = w_en;
    assign i_cfg.ready = 1'b1;
    assign o_pix.valid = r_vld[ecp_pkg::LAST_STAGE];
    assign o_pix.rgb   = r_rgb;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ecp_pkg::MODE_POLY;
            r_max  <= ecp_pkg::MAX_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ecp_pkg::REG_MODE: r_mode <= i_cfg.data[ecp_pkg::MODE_WIDTH-1:0];
                ecp_pkg::REG_MAX:  r_max  <= i_cfg.data[ecp_pkg::MAX_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // sine lanes run beside the divider, result lines up with stage seven
    assign w_sine_b = (r_st[0].mode == ecp_pkg::MODE_SINE_B);
    for (genvar c = 0; c < 3; c++) begin : g_lane
        ecp_sine_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_cnt     (r_st[0].cnt),
            .i_inc     (w_sine_b ? ecp_pkg::SINE_B_INC[c] : ecp_pkg::SINE_A_INC[c]),
            .i_ofs     (w_sine_b ? ecp_pkg::SINE_B_OFS[c] : ecp_pkg::SINE_A_OFS[c]),
            .i_hi_bias (!w_sine_b),
            .o_chan    (w_sc[c])
        );
    end

    // stage logic
    always_comb begin
        logic [ecp_pkg::MAX_WIDTH:0] s1, s2;
        logic [16:0] tq, uq;
        logic [33:0] pr, pg, pb;
        logic [28:0] mr;
        logic [28:0] mg;
        logic [29:0] mb;
        logic [7:0]  cr, cg, cb, ramp;
        logic [23:0] rp;
        logic [23:0] a5, a3, a4;
        logic        black;
        ecp_pkg::t_stage st;

        // input stage
        st      = '0;
        st.cnt  = i_pix.count;
        st.maxc = (r_max == '0) ? ecp_pkg::MAX_WIDTH'(1) : r_max;
        st.mode = (r_mode > ecp_pkg::MODE_MUL_B) ? ecp_pkg::MODE_SINE_A : r_mode;
        st.rem  = ecp_pkg::MAX_WIDTH'(i_pix.count);
        n_st[0] = st;

        // divider, two quotient bits per stage
        for (int k = 1; k <= ecp_pkg::DIV_STAGES; k++) begin
            st     = r_st[k-1];
            s1     = ecp_pkg::div_step(st.rem, st.maxc);
            s2     = ecp_pkg::div_step(s1[ecp_pkg::MAX_WIDTH-1:0], st.maxc);
            st.quo = {st.quo[13:0], s1[ecp_pkg::MAX_WIDTH], s2[ecp_pkg::MAX_WIDTH]};
            st.rem = s2[ecp_pkg::MAX_WIDTH-1:0];
            if (k == ecp_pkg::DIV_STAGES) begin
                st.sr = w_sc[0];
                st.sg = w_sc[1];
                st.sb = w_sc[2];
            end
            n_st[k] = st;
        end

        // first products: u*t and u*u
        st      = r_st[8];
        tq      = {1'b0, st.quo};
        uq      = 17'd65536 - tq;
        pr      = 34'(uq) * 34'(tq);
        pg      = 34'(uq) * 34'(uq);
        st.pr   = pr[32:16];
        st.pg   = pg[32:16];
        st.pb   = pg[32:16];
        n_st[9] = st;

        // second products
        st       = r_st[9];
        tq       = {1'b0, st.quo};
        uq       = 17'd65536 - tq;
        pr       = 34'(st.pr) * 34'(tq);
        pg       = 34'(st.pg) * 34'(tq);
        pb       = 34'(st.pb) * 34'(uq);
        st.pr    = pr[32:16];
        st.pg    = pg[32:16];
        st.pb    = pb[32:16];
        n_st[10] = st;

        // third products
        st       = r_st[10];
        tq       = {1'b0, st.quo};
        pr       = 34'(st.pr) * 34'(tq);
        pg       = 34'(st.pg) * 34'(tq);
        pb       = 34'(st.pb) * 34'(tq);
        st.pr    = pr[32:16];
        st.pg    = pg[32:16];
        st.pb    = pb[32:16];
        n_st[11] = st;

        // output stage: scale, ramp, packing per mode
        st    = r_st[11];
        mr    = 29'(st.pr) * 29'd2295;
        mg    = 29'(st.pg) * 29'd3825;
        mb    = 30'(st.pb) * 30'd4335;
        cr    = (mr[28:16] > 13'd255) ? 8'd255 : mr[23:16];
        cg    = (mg[28:16] > 13'd255) ? 8'd255 : mg[23:16];
        cb    = (mb[29:17] > 13'd255) ? 8'd255 : mb[24:17];
        rp    = 24'(st.quo) * 24'd255;
        ramp  = rp[23:16];
        a5    = 24'(st.cnt) * 24'd5;
        a3    = 24'(st.cnt) * 24'd3;
        a4    = 24'(st.cnt) << 2;
        black = (32'(st.cnt) >= 32'(st.maxc));
        case (st.mode)
            ecp_pkg::MODE_POLY:   n_rgb = {cr, cg, cb};
            ecp_pkg::MODE_RED:    n_rgb = {ramp, 16'd0};
            ecp_pkg::MODE_GREEN:  n_rgb = {8'd0, ramp, 8'd0};
            ecp_pkg::MODE_BLUE:   n_rgb = {16'd0, ramp};
            ecp_pkg::MODE_MOD:    n_rgb = {8'(st.cnt[7:0] * 8'd9), st.cnt[6:0], 1'b0,
                                           st.cnt[7:0]};
            ecp_pkg::MODE_MUL_A:  n_rgb = {a5[15:0], 8'd0} | a3;
            ecp_pkg::MODE_MUL_B:  n_rgb = {st.cnt[6:0], 1'b0, 16'd0} | a4;
            default:              n_rgb = {st.sr, st.sg, st.sb};
        endcase
        if (black) begin
            n_rgb = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ecp_pkg::LAST_STAGE; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_pix.valid;
            for (int k = 1; k <= ecp_pkg::LAST_STAGE; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < ecp_pkg::LAST_STAGE; k++) begin
                r_st[k] <= n_st[k];
            end
            r_rgb <= n_rgb;
        end
    end

endmodule

[src/ecp_checker.sv]
// port level checks of the palette block and their binding
module ecp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cfg_ready
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input side stalls exactly when a result is held
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    // a held result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // an offered count beat stays until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("count beat withdrawn while stalled");

    // configuration writes never stall
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind escape_count_color_palette ecp_checker u_ecp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_cfg_ready (i_cfg.ready)
);

[test/ecp_tb_if.sv]
// testbench-side note: interfaces come from the rtl; this file holds the beat record type
package ecp_tb_pkg;
    import ecp_pkg::*;

    // one color expectation together with the count that produced it
    typedef struct {
        logic [COUNT_WIDTH-1:0] count;
        logic [RGB_WIDTH-1:0]   rgb;
    } t_color_exp;
endpackage

[test/tb.sv]
// testbench for the escape count color palette: predicts each pixel color and checks the stream
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ecp_pkg::*;
    import ecp_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_fail = 0;
    int   idle_cycles = 0;
    bit   gaps_on = 1'b1;
    bit   hold_sink = 1'b0;
    t_color_exp colors_due[$];

    // palette settings as the predictor sees them
    logic [MODE_WIDTH-1:0] cur_mode = MODE_POLY;
    logic [MAX_WIDTH-1:0]  cur_max = MAX_RESET;

    ecp_cfg_if cfg ();
    ecp_cnt_if pix ();
    ecp_rgb_if col ();

    escape_count_color_palette u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (pix),
        .o_pix   (col)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        pix.valid = 1'b0;
        pix.count = '0;
        col.ready = 1'b0;
    end

    // sine magnitude of one quadrant, z in Q0.14
    function automatic logic [31:0] quad_sine(input logic [31:0] z);
        logic [63:0] z15, z2, t1, t2, t3, t4, s;
        z15 = {32'd0, z} << 1;
        z2 = (z15 * z15) >> 15;
        t1 = (z2 * 64'(SIN_C)) >> 15;
        t2 = 64'(SIN_B) - t1;
        t3 = (z2 * t2) >> 15;
        t4 = 64'(SIN_A) - t3;
        s = (z15 * t4) >> 15;
        return (s > 64'd32768) ? 32'd32768 : s[31:0];
    endfunction

    // one sine channel from a count, phase increment, offset and bias
    function automatic logic [7:0] sine_level(input logic [15:0] c, input logic [31:0] inc,
                                             input logic [31:0] ofs, input int unsigned bias);
        logic [31:0] ph, m, z;
        logic [15:0] p16;
        logic [1:0]  q;
        int unsigned d;
        ph = 32'(c) * inc + ofs;
        p16 = ph[31:16];
        q = p16[15:14];
        z = q[0] ? 32'd16384 - 32'(p16[13:0]) : 32'(p16[13:0]);
        m = quad_sine(z);
        if (!q[1]) begin
            d = (127 * m) >> 15;
            return (bias + d > 255) ? 8'd255 : 8'(bias + d);
        end
        d = (127 * m + 32767) >> 15;
        return (d > bias) ? 8'd0 : 8'(bias - d);
    endfunction

    function automatic logic [7:0] sat8(input logic [63:0] v);
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    // color of one pixel under the current settings
    function automatic logic [RGB_WIDTH-1:0] pixel_color(input logic [15:0] c);
        logic [63:0] mx, t, u, p;
        logic [7:0]  r, g, b, ramp;
        logic [3:0]  md;
        logic [63:0] wide;
        mx = (cur_max == 0) ? 64'd1 : 64'(cur_max);
        if (64'(c) >= mx) return '0;
        t = (64'(c) << 16) / mx;
        u = 64'd65536 - t;
        ramp = 8'((255 * t) >> 16);
        md = (cur_mode > MODE_MUL_B) ? MODE_SINE_A : cur_mode;
        case (md)
            MODE_POLY: begin
                p = ((((u * t) >> 16) * t >> 16) * t) >> 16;
                r = sat8((2295 * p) >> 16);
                p = ((((u * u) >> 16) * t >> 16) * t) >> 16;
                g = sat8((3825 * p) >> 16);
                p = ((((u * u) >> 16) * u >> 16) * t) >> 16;
                b = sat8((4335 * p) >> 17);
                return {r, g, b};
            end
            MODE_RED: return {ramp, 16'd0};
            MODE_GREEN: return {8'd0, ramp, 8'd0};
            MODE_BLUE: return {16'd0, ramp};
            MODE_SINE_A: begin
                return {sine_level(c, SINE_A_INC[0], SINE_A_OFS[0], 128),
                        sine_level(c, SINE_A_INC[1], SINE_A_OFS[1], 128),
                        sine_level(c, SINE_A_INC[2], SINE_A_OFS[2], 128)};
            end
            MODE_MOD: return {8'(c * 9), 8'(c * 2), 8'(c)};
            MODE_SINE_B: begin
                return {sine_level(c, SINE_B_INC[0], SINE_B_OFS[0], 127),
                        sine_level(c, SINE_B_INC[1], SINE_B_OFS[1], 127),
                        sine_level(c, SINE_B_INC[2], SINE_B_OFS[2], 127)};
            end
            MODE_MUL_A: begin
                wide = ((64'(c) * 5) << 8) | (64'(c) * 3);
                return wide[23:0];
            end
            default: begin
                wide = ((64'(c) * 2) << 16) | (64'(c) * 4);
                return wide[23:0];
            end
        endcase
    endfunction

    // send one count beat and record its color; valid stays up for a following beat
    task automatic send_count(input logic [15:0] c);
        t_color_exp e;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.count <= c;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        e.count = c;
        e.rgb = pixel_color(c);
        colors_due.push_back(e);
    endtask

    // wait for all colors plus the pipeline latency, then write a register
    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [15:0] v);
        pix.valid <= 1'b0;
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (LAST_STAGE + 4) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == REG_MODE) cur_mode = v[3:0];
        else if (idx == REG_MAX) cur_max = v;
    endtask

    task automatic set_palette(input logic [3:0] md, input logic [15:0] mx);
        write_reg(REG_MODE, {12'd0, md});
        write_reg(REG_MAX, mx);
    endtask

    // reset values, then directed extremes in every palette
    task automatic test_directed();
        logic [15:0] edges[6];
        edges = '{16'd0, 16'd1, 16'd255, 16'd256, 16'hAAAA, 16'hFFFF};
        foreach (edges[i]) send_count(edges[i]);
        set_palette(MODE_POLY, 16'hFFFF);
        send_count(16'd0);
        send_count(16'h5555);
        send_count(16'hFFFE);
        send_count(16'hFFFF);
        // zero limit behaves as one
        set_palette(MODE_RED, 16'd0);
        send_count(16'd0);
        send_count(16'd1);
        // unused selector falls back to the first sine palette
        set_palette(4'd15, 16'hFFFF);
        send_count(16'd1234);
        // unknown register index is ignored
        write_reg(4'd9, 16'hFFFF);
        send_count(16'h7FFF);
        for (int m = 0; m <= 9; m++) begin
            set_palette(m[3:0], 16'hFFFF);
            send_count(16'hFFFE);
            send_count(16'($urandom));
        end
    endtask

    // random counts under a series of settings
    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: set_palette(4'($urandom), 16'hFFFF);
                    1: set_palette(4'($urandom), 16'($urandom_range(0, 4)));
                    2: set_palette(4'($urandom), 16'($urandom));
                    default: set_palette(4'($urandom_range(0, 8)), 16'($urandom_range(1, 1024)));
                endcase
            end
            if ($urandom_range(0, 1)) send_count(16'($urandom));
            else send_count(16'($urandom_range(0, cur_max)));
        end
    endtask

    // long sink hold while counts keep coming, so the pipeline backs up
    task automatic test_backpressure();
        set_palette(MODE_MOD, 16'hFFFF);
        hold_sink = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < 60; k++) send_count(16'($urandom));
        join
    endtask

    // sink readiness with random stall bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_sink) begin
                col.ready <= 1'b0;
                @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                col.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                col.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare each color beat with the oldest expectation
    always @(posedge i_clk) begin
        t_color_exp e;
        if (i_rst_n && col.valid && col.ready) begin
            if (colors_due.size() == 0) begin
                $error("unexpected color beat rgb=%h", col.rgb);
                n_fail++;
            end else begin
                e = colors_due.pop_front();
                if (col.rgb !== e.rgb) begin
                    $error("rgb count=%0d expected %h actual %h", e.count, e.rgb, col.rgb);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (col.valid && col.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1100);
        gaps_on = 1'b0;
        test_random(200);
        pix.valid <= 1'b0;
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (LAST_STAGE + 4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[files.f]
src/ecp_pkg.sv
src/ecp_if.sv
src/ecp_sine_lane.sv
src/escape_count_color_palette.sv
src/ecp_checker.sv
test/ecp_tb_if.sv
test/tb.sv
